// File: hw/rtl/sac_pkg.sv
`timescale 1ns / 1ps

package sac_pkg;

   // geometry
   localparam int WAYS   = 4;
   localparam int SETS   = 64;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int RANK_W = WAY_W;

   // field widths
   localparam int ADDR_W      = 32;
   localparam int TAG_W       = 32;
   localparam int SET_INDEX_W = 6;
   localparam int OFFSET_W    = 30;
   localparam int COUNT_W     = 32;
   localparam int CSR_W       = 6;
   localparam int CSR_INDEX_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAG_BITS    = 2'd2;

   // register reset values
   localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
   localparam logic [2:0] INDEX_BITS_RST  = 3'd6;
   localparam logic [5:0] TAG_BITS_RST    = 6'd0;

   // commands
   localparam logic CMD_ACCESS = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] addr;
   } sac_req_type;

   typedef struct packed {
      logic                   hit;
      logic [WAY_W-1:0]       way;
      logic                   evicted;
      logic [TAG_W-1:0]       evicted_tag;
      logic [TAG_W-1:0]       tag_part;
      logic [SET_INDEX_W-1:0] set_index;
      logic [OFFSET_W-1:0]    byte_offset;
      logic [COUNT_W-1:0]     hit_total;
      logic [COUNT_W-1:0]     miss_total;
   } sac_rsp_type;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [RANK_W-1:0] rank;
   } sac_way_type;

   typedef sac_way_type [WAYS-1:0] sac_row_type;

   localparam int ROW_W = $bits(sac_row_type);

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic             evicted;
      logic [TAG_W-1:0] evicted_tag;
   } sac_lookup_type;

endpackage

// File: hw/rtl/sac_ram.sv
`timescale 1ns / 1ps

module sac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/sac_addr_split.sv
`timescale 1ns / 1ps

module sac_addr_split (
   input  logic [sac_pkg::ADDR_W-1:0]      addr,
   input  logic [4:0]                      offset_bits,
   input  logic [2:0]                      index_bits,
   input  logic [5:0]                      tag_bits,
   output logic [sac_pkg::TAG_W-1:0]       tag_part,
   output logic [sac_pkg::SET_INDEX_W-1:0] set_index,
   output logic [sac_pkg::OFFSET_W-1:0]    byte_offset
);
   import sac_pkg::*;

   localparam logic [ADDR_W-1:0] ONES = '1;

   logic [ADDR_W-1:0] off_full;
   logic [ADDR_W-1:0] idx_full;
   logic [5:0]        used;
   logic [5:0]        tbits;
   logic [ADDR_W-1:0] tag_mask;

   // offset and index fields, the offset never reaches past the address
   assign off_full = addr & ~(ONES << offset_bits);
   assign idx_full = (addr >> offset_bits) & ~(ONES << index_bits);

   // tag width, zero means all bits above index and offset
   assign used = {1'b0, offset_bits} + {3'b000, index_bits};

   always_comb begin
      if (tag_bits != 6'd0) begin
         tbits = tag_bits;
      end else if (used >= 6'd32) begin
         tbits = 6'd0;
      end else begin
         tbits = 6'd32 - used;
      end
   end

   assign tag_mask = (tbits >= 6'd32) ? ONES : ~(ONES << tbits[4:0]);

   // tag field, zero once the shift leaves the address
   assign tag_part    = (used >= 6'd32) ? '0 : ((addr >> used[4:0]) & tag_mask);
   assign set_index   = idx_full[SET_INDEX_W-1:0];
   assign byte_offset = off_full[OFFSET_W-1:0];

endmodule

// File: hw/rtl/sac_way_logic.sv
`timescale 1ns / 1ps

module sac_way_logic (
   input  sac_pkg::sac_row_type            row,
   input  logic [sac_pkg::TAG_W-1:0]       tag,
   output sac_pkg::sac_lookup_type         lookup,
   output sac_pkg::sac_row_type            row_new
);
   import sac_pkg::*;

   logic              found;
   logic [WAY_W-1:0]  hit_way;
   logic              have_invalid;
   logic [WAY_W-1:0]  invalid_way;
   logic [WAY_W-1:0]  lru_way;
   logic [RANK_W-1:0] oldest;
   logic [WAY_W-1:0]  victim;
   logic              was_valid;
   logic [RANK_W-1:0] old_rank;

   // first valid way holding the tag
   always_comb begin
      found   = 1'b0;
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && row[w].valid && row[w].tag == tag) begin
            found   = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
   end

   // first invalid way
   always_comb begin
      have_invalid = 1'b0;
      invalid_way  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!have_invalid && !row[w].valid) begin
            have_invalid = 1'b1;
            invalid_way  = WAY_W'(w);
         end
      end
   end

   // oldest way, lowest number wins a tie
   always_comb begin
      lru_way = '0;
      oldest  = row[0].rank;
      for (int w = 1; w < WAYS; w++) begin
         if (row[w].rank > oldest) begin
            oldest  = row[w].rank;
            lru_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      priority if (found) begin
         victim = hit_way;
      end else if (have_invalid) begin
         victim = invalid_way;
      end else begin
         victim = lru_way;
      end
   end

   assign was_valid = row[victim].valid;
   assign old_rank  = row[victim].rank;

   // age younger valid ways, install or keep the tag, victim most recent
   always_comb begin
      row_new = row;
      for (int i = 0; i < WAYS; i++) begin
         if (WAY_W'(i) != victim && row[i].valid) begin
            if (!was_valid || row[i].rank < old_rank) begin
               row_new[i].rank = row[i].rank + RANK_W'(1);
            end
         end
      end
      row_new[victim].valid = 1'b1;
      row_new[victim].tag   = tag;
      row_new[victim].rank  = '0;
   end

   assign lookup.hit         = found;
   assign lookup.way         = victim;
   assign lookup.evicted     = !found && was_valid;
   assign lookup.evicted_tag = found ? '0 : row[victim].tag;

endmodule

// File: hw/rtl/set_assoc_cache_lru_tags_core.sv
`timescale 1ns / 1ps

// Tag-only 4-way set-associative cache with LRU replacement over 64 sets.
// An item is accepted when start is high and busy is low; its result appears
// on rsp_item with rsp_valid high for exactly one cycle, registered after
// the lookup stage; rsp_valid is not held. busy is high while an item
// is in the lookup stage, so the block takes no new item during a lookup:
// the set's row is read from a memory with a registered read, then updated
// and written back in the next cycle. Each set has a live flag in flip-flops
// that reset and the clear command drop at once, so there is no clearing pass
// after reset. Configuration writes go to csr_index 0 (offset bits), 1 (index
// bits) and 2 (tag bits) and should be made only while no item is in flight.
module set_assoc_cache_lru_tags_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  sac_pkg::sac_req_type             req_item,
   output logic                             rsp_valid,
   output sac_pkg::sac_rsp_type             rsp_item,
   input  logic                             csr_wr_en,
   input  logic [sac_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sac_pkg::CSR_W-1:0]        csr_wdata
);
   import sac_pkg::*;

   // configuration registers
   logic [4:0] offset_bits_ff;
   logic [2:0] index_bits_ff;
   logic [5:0] tag_bits_ff;

   // lookup stage
   logic                   s1_valid_ff;
   logic                   s1_cmd_ff;
   logic [TAG_W-1:0]       s1_tag_ff;
   logic [SET_INDEX_W-1:0] s1_set_index_ff;
   logic [OFFSET_W-1:0]    s1_offset_ff;

   logic [SETS-1:0]    set_live_ff, set_live_in;
   logic [COUNT_W-1:0] hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0] miss_count_ff, miss_count_in;
   logic               rsp_valid_ff;
   sac_rsp_type        rsp_ff, rsp_in;

   logic                   accept;
   logic [TAG_W-1:0]       split_tag;
   logic [SET_INDEX_W-1:0] split_set_index;
   logic [OFFSET_W-1:0]    split_offset;
   logic [SET_W-1:0]       s1_set;
   logic [ROW_W-1:0]       ram_rdata;
   sac_row_type            row_cur;
   sac_row_type            row_new;
   sac_lookup_type         lookup;
   logic                   do_access;

   assign accept    = start && !busy;
   assign busy      = s1_valid_ff;
   assign s1_set    = s1_set_index_ff[SET_W-1:0];
   assign do_access = s1_valid_ff && (s1_cmd_ff == CMD_ACCESS);

   // configuration writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_BITS_RST;
         index_bits_ff  <= INDEX_BITS_RST;
         tag_bits_ff    <= TAG_BITS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata[4:0];
            CSR_INDEX_BITS:  index_bits_ff  <= csr_wdata[2:0];
            CSR_TAG_BITS:    tag_bits_ff    <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   sac_addr_split u_split (
      .addr        (req_item.addr),
      .offset_bits (offset_bits_ff),
      .index_bits  (index_bits_ff),
      .tag_bits    (tag_bits_ff),
      .tag_part    (split_tag),
      .set_index   (split_set_index),
      .byte_offset (split_offset)
   );

   // capture the item while its row is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff       <= req_item.cmd;
         s1_tag_ff       <= split_tag;
         s1_set_index_ff <= split_set_index;
         s1_offset_ff    <= split_offset;
      end
   end

   sac_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (do_access),
      .wr_addr (s1_set),
      .wr_data (row_new),
      .rd_en   (accept),
      .rd_addr (split_set_index[SET_W-1:0]),
      .rd_data (ram_rdata)
   );

   // a set not written since the last clear reads as empty
   assign row_cur = set_live_ff[s1_set] ? sac_row_type'(ram_rdata) : '0;

   sac_way_logic u_ways (
      .row     (row_cur),
      .tag     (s1_tag_ff),
      .lookup  (lookup),
      .row_new (row_new)
   );

   // counters and set live flags
   always_comb begin
      set_live_in   = set_live_ff;
      hit_count_in  = hit_count_ff;
      miss_count_in = miss_count_ff;
      if (s1_valid_ff) begin
         if (s1_cmd_ff == CMD_CLEAR) begin
            set_live_in   = '0;
            hit_count_in  = '0;
            miss_count_in = '0;
         end else begin
            set_live_in[s1_set] = 1'b1;
            if (lookup.hit) begin
               if (hit_count_ff != COUNT_MAX) begin
                  hit_count_in = hit_count_ff + COUNT_W'(1);
               end
            end else if (miss_count_ff != COUNT_MAX) begin
               miss_count_in = miss_count_ff + COUNT_W'(1);
            end
         end
      end
   end

   // result of the item, all zero for a clear
   always_comb begin
      rsp_in = '0;
      if (s1_cmd_ff == CMD_ACCESS) begin
         rsp_in.hit         = lookup.hit;
         rsp_in.way         = lookup.way;
         rsp_in.evicted     = lookup.evicted;
         rsp_in.evicted_tag = lookup.evicted_tag;
         rsp_in.tag_part    = s1_tag_ff;
         rsp_in.set_index   = s1_set_index_ff;
         rsp_in.byte_offset = s1_offset_ff;
         rsp_in.hit_total   = hit_count_in;
         rsp_in.miss_total  = miss_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_live_ff   <= '0;
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         set_live_ff   <= set_live_in;
         hit_count_ff  <= hit_count_in;
         miss_count_ff <= miss_count_in;
         rsp_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   // every item in the lookup stage yields a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("lookup stage did not produce a result");

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.hit && rsp_item.evicted))
      else $error("hit reported with an eviction");

   // a hit result carries a nonzero hit total
   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.hit) |-> (rsp_item.hit_total != '0))
      else $error("hit not counted");

   // a clear yields zero totals after the lookup stage and the result register
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.cmd == CMD_CLEAR) |=> ##1
      (rsp_valid && rsp_item.hit_total == '0 && rsp_item.miss_total == '0))
      else $error("clear did not zero the counters");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sac_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int LINES       = WAYS * SETS;
   localparam int STALL_LIMIT = 3000;
   localparam int MAX_REPORTS = 10;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 225;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   sac_req_type            req_item;
   logic                   rsp_valid;
   sac_rsp_type            rsp_item;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]       csr_wdata;

   set_assoc_cache_lru_tags_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the cache: settings, lines, ages and counters
   int unsigned  cfg_offset;
   int unsigned  cfg_index;
   int unsigned  cfg_tag;
   bit           line_ok   [LINES];
   logic [31:0]  line_tags [LINES];
   byte unsigned line_age  [LINES];
   logic [31:0]  hits_seen;
   logic [31:0]  misses_seen;

   sac_rsp_type  pending_rsps[$];
   int unsigned  error_count = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  sender_idle_pct = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] bit_mask(int unsigned w);
      if (w >= 32) return 32'hffff_ffff;
      return 32'((64'd1 << w) - 64'd1);
   endfunction

   // bits above the address read as zero
   function automatic logic [31:0] addr_field(logic [31:0] a, int unsigned sh, int unsigned w);
      if (sh >= 32) return 32'd0;
      return (a >> sh) & bit_mask(w);
   endfunction

   function automatic void wipe_lines();
      for (int i = 0; i < LINES; i++) begin
         line_ok[i]   = 1'b0;
         line_tags[i] = 32'd0;
         line_age[i]  = 8'd0;
      end
      hits_seen   = 32'd0;
      misses_seen = 32'd0;
   endfunction

   // make way w of the set the most recent, aging the younger valid ways
   function automatic void promote(int unsigned base, int unsigned w);
      bit           was_valid;
      byte unsigned old_age;
      was_valid = line_ok[base + w];
      old_age   = line_age[base + w];
      for (int i = 0; i < WAYS; i++) begin
         if (i != w && line_ok[base + i] && (!was_valid || line_age[base + i] < old_age))
            line_age[base + i]++;
      end
      line_age[base + w] = 8'd0;
   endfunction

   // lookup, replacement and counter update for one item
   function automatic sac_rsp_type cache_access(sac_req_type r);
      sac_rsp_type res;
      int unsigned tw;
      int unsigned used;
      int unsigned base;
      int unsigned vic;
      int unsigned oldest;
      logic [31:0] tg;
      logic [31:0] ix;
      logic [31:0] of;
      bit          found;
      bit          have_free;
      res = '0;
      if (r.cmd == CMD_CLEAR) begin
         wipe_lines();
         return res;
      end
      tw = cfg_tag;
      if (tw == 0) begin
         used = cfg_index + cfg_offset;
         tw = (used >= 32) ? 0 : 32 - used;
      end
      of = r.addr & bit_mask(cfg_offset);
      ix = addr_field(r.addr, cfg_offset, cfg_index);
      tg = addr_field(r.addr, cfg_offset + cfg_index, tw);
      base = (ix % SETS) * WAYS;
      found = 1'b0;
      vic = 0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && line_ok[base + w] && line_tags[base + w] == tg) begin
            vic = w;
            found = 1'b1;
         end
      end
      if (found) begin
         promote(base, vic);
         if (hits_seen != COUNT_MAX) hits_seen++;
         res.hit = 1'b1;
      end else begin
         // first free way, else the oldest one
         have_free = 1'b0;
         for (int w = 0; w < WAYS; w++) begin
            if (!have_free && !line_ok[base + w]) begin
               vic = w;
               have_free = 1'b1;
            end
         end
         if (!have_free) begin
            oldest = 0;
            for (int w = 0; w < WAYS; w++) begin
               if (w == 0 || line_age[base + w] > oldest) begin
                  oldest = 32'(line_age[base + w]);
                  vic = w;
               end
            end
         end
         if (misses_seen != COUNT_MAX) misses_seen++;
         res.evicted     = line_ok[base + vic];
         res.evicted_tag = line_tags[base + vic];
         promote(base, vic);
         line_ok[base + vic]   = 1'b1;
         line_tags[base + vic] = tg;
      end
      res.way         = vic[WAY_W-1:0];
      res.tag_part    = tg;
      res.set_index   = ix[SET_INDEX_W-1:0];
      res.byte_offset = of[OFFSET_W-1:0];
      res.hit_total   = hits_seen;
      res.miss_total  = misses_seen;
      return res;
   endfunction

   // hand one item over and record what it should return
   task automatic send_item(input sac_req_type it);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      pending_rsps.push_back(cache_access(it));
   endtask

   task automatic access(input logic [31:0] a);
      sac_req_type it;
      it.cmd  = CMD_ACCESS;
      it.addr = a;
      send_item(it);
   endtask

   task automatic clear_cmd();
      sac_req_type it;
      it.cmd  = CMD_CLEAR;
      it.addr = $urandom;
      send_item(it);
   endtask

   // stop sending and wait until every result is back
   task automatic drain(input int unsigned extra);
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_W-1:0] val);
      drain(2);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_OFFSET_BITS: cfg_offset = 32'(val[4:0]);
         CSR_INDEX_BITS:  cfg_index  = 32'(val[2:0]);
         CSR_TAG_BITS:    cfg_tag    = 32'(val[5:0]);
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned ob, input int unsigned ib, input int unsigned tb);
      write_reg(CSR_OFFSET_BITS, CSR_W'(ob));
      write_reg(CSR_INDEX_BITS, CSR_W'(ib));
      write_reg(CSR_TAG_BITS, CSR_W'(tb));
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin : check_rsp
      sac_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("mismatch: unexpected result %h", rsp_item);
         end else begin
            want = pending_rsps.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_item.hit));
            check_field("way", 32'(want.way), 32'(rsp_item.way));
            check_field("evicted", 32'(want.evicted), 32'(rsp_item.evicted));
            check_field("evicted_tag", want.evicted_tag, rsp_item.evicted_tag);
            check_field("tag_part", want.tag_part, rsp_item.tag_part);
            check_field("set_index", 32'(want.set_index), 32'(rsp_item.set_index));
            check_field("byte_offset", 32'(want.byte_offset), 32'(rsp_item.byte_offset));
            check_field("hit_total", want.hit_total, rsp_item.hit_total);
            check_field("miss_total", want.miss_total, rsp_item.miss_total);
         end
      end
   end

   // watchdog on cycles with no handshake at all, stray results do not count
   always @(posedge clock) begin
      if (reset || (rsp_valid && pending_rsps.size() != 0) || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // default geometry: hits, fills, lru eviction, clear
   task automatic test_directed();
      access(32'h0000_0000);                 // miss into an empty way, tag zero
      access(32'h0000_000f);                 // hit, largest offset
      access(32'hffff_ffff);                 // top set, all-ones tag
      access(32'hffff_fff0);
      for (int t = 1; t <= 4; t++) access((t << 10) | (5 << 4));
      access((1 << 10) | (5 << 4) | 3);      // way 0 becomes most recent
      drain(0);
      access((5 << 10) | (5 << 4));          // set full: lru victim
      access((2 << 10) | (5 << 4));
      access((4 << 10) | (5 << 4));
      access((6 << 10) | (5 << 4));
      clear_cmd();
      access((1 << 10) | (5 << 4));          // free way after clear, old tag reads zero
      access(32'h0000_0000);
      access(32'h8000_0000);
   endtask

   // settings at the edges of the register ranges
   task automatic test_field_corners();
      configure(30, 6, 0);                   // auto tag width goes negative
      access(32'hffff_ffff);
      access(32'h4000_0000);
      configure(31, 7, 63);                  // fields past bit 31, offset wider than its port
      access(32'hffff_ffff);
      access(32'h8000_0001);
      configure(0, 7, 63);                   // index beyond the set count, wide tag
      access(32'h0000_007f);
      access(32'h0000_003f);
      configure(0, 0, 32);                   // no index, full-width tag
      access(32'hffff_ffff);
      write_reg(CSR_UNUSED, 6'h3f);          // write to a missing register is dropped
      access(32'h0000_0000);
   endtask

   // random traffic over a small working set per phase
   task automatic test_random();
      int unsigned offs [PHASES] = '{4, 0, 31, 30, 2, 5, 0, 12};
      int unsigned idxs [PHASES] = '{6, 0, 7, 6, 3, 2, 6, 1};
      int unsigned tags [PHASES] = '{0, 0, 0, 0, 63, 10, 32, 1};
      int unsigned idle_pct [4]  = '{0, 88, 0, 33};
      logic [31:0] tag_pool [6];
      logic [31:0] set_pool [3];
      logic [63:0] a64;
      sac_req_type it;
      int unsigned pick;
      for (int p = 0; p < PHASES; p++) begin
         configure(offs[p], idxs[p], tags[p]);
         sender_idle_pct = idle_pct[p % 4];
         for (int k = 0; k < 6; k++) tag_pool[k] = (k < 3) ? k : $urandom;
         for (int k = 0; k < 3; k++) set_pool[k] = $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            while ($urandom_range(99) < sender_idle_pct) begin
               @(negedge clock);
               start <= 1'b0;
            end
            pick = $urandom_range(99);
            it.cmd  = CMD_ACCESS;
            it.addr = $urandom;
            if (pick < 3) begin
               it.cmd = CMD_CLEAR;
            end else if (pick >= 13) begin
               a64 = (64'(tag_pool[$urandom_range(5)]) << (cfg_offset + cfg_index))
                   | (64'(set_pool[$urandom_range(2)] & bit_mask(cfg_index)) << cfg_offset)
                   | 64'($urandom & bit_mask(cfg_offset));
               it.addr = a64[31:0];
            end
            send_item(it);
         end
      end
   endtask

   initial begin
      start     = 1'b0;
      req_item  = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_OFFSET_BITS;
      csr_wdata = '0;
      reset     = 1'b1;
      cfg_offset = 32'(OFFSET_BITS_RST);
      cfg_index  = 32'(INDEX_BITS_RST);
      cfg_tag    = 32'(TAG_BITS_RST);
      wipe_lines();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_field_corners();
      test_random();
      drain(6);

      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
